// ===== src/priority_queue_with_skip_defines.svh =====
`ifndef PRIORITY_QUEUE_WITH_SKIP_DEFINES_SVH
`define PRIORITY_QUEUE_WITH_SKIP_DEFINES_SVH

// Assertion macros shared by the queue RTL.
`define PQS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`define PQS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/pqs_pkg.sv =====
package pqs_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam logic [15:0] SPACING_RESET = 16'd10;

    typedef enum logic [3:0] {
        ACT_INSERT     = 4'd0,
        ACT_INSERT_TOP = 4'd1,
        ACT_INSERT_BOT = 4'd2,
        ACT_PEEK_TOP   = 4'd3,
        ACT_PEEK_CUR   = 4'd4,
        ACT_SKIP       = 4'd5,
        ACT_POP_TOP    = 4'd6,
        ACT_POP_CUR    = 4'd7,
        ACT_REMOVE     = 4'd8,
        ACT_CLEAR      = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [15:0]        item_type;
        logic signed [31:0] priority_value;
        logic               blocking;
    } entry_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic [15:0] s,
                                                   input logic sub);
        logic signed [33:0] w;
        begin
            w = sub ? ({{2{a[31]}}, a} - {18'd0, s}) : ({{2{a[31]}}, a} + {18'd0, s});
            if (w > 34'sh0_7FFF_FFFF)
                sat_add = 32'sh7FFF_FFFF;
            else if (w < -34'sh0_8000_0000)
                sat_add = 32'sh8000_0000;
            else
                sat_add = w[31:0];
        end
    endfunction

endpackage

// ===== src/pqs_mem.sv =====
module pqs_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW = 6
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pqs_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output pqs_pkg::entry_t rdata
);
    import pqs_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== src/priority_queue_with_skip.sv =====
// Sorted priority queue held in one entry memory with a registered read port.
// One action is taken at a time, and the next transfer is accepted only after
// the result has been transferred. Peek, skip and a pop of the top read at most
// one entry. A sorted insert, a pop of the current entry or a type removal moves
// entries one at a time through the memory, each by a read state and a write
// state. The search for a sorted place, or for a matching type, also reads one
// entry at a time, through a read state and a wait state. The result is held in
// an output register until transferred.
`include "priority_queue_with_skip_defines.svh"
module priority_queue_with_skip #(
    parameter int unsigned DEPTH = pqs_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         action,
    input  logic [15:0]        item_type,
    input  logic signed [31:0] item_priority,
    input  logic               item_blocking,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        out_type,
    output logic signed [31:0] out_priority,
    output logic               out_blocking,
    output logic               skipped_ok,
    output logic               removed_ok,
    output logic [$clog2(DEPTH+1)-1:0] entry_count,
    output logic [1:0]         status
);
    import pqs_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FIND   = 9'b000000010,
        S_FINDW  = 9'b000000100,
        S_SHUPR  = 9'b000001000,
        S_SHUPW  = 9'b000010000,
        S_SHDNR  = 9'b000100000,
        S_SHDNW  = 9'b001000000,
        S_TOPR   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] held_reg, held_next;
    logic [AW-1:0] skip_reg, skip_next;
    logic signed [31:0] top_reg, top_next, bot_reg, bot_next;
    logic [15:0] spacing_reg;
    logic [CW-1:0] idx_reg, idx_next, pos_reg, pos_next;
    logic [3:0] act_reg, act_next;
    entry_t new_reg, new_next;
    logic peek_reg, peek_next;

    logic [15:0] o_type_reg, o_type_next;
    logic signed [31:0] o_pri_reg, o_pri_next;
    logic o_blk_reg, o_blk_next, o_skip_reg, o_skip_next, o_rem_reg, o_rem_next;
    logic [1:0] o_st_reg, o_st_next;
    logic o_valid_reg, o_valid_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wdata, rdata;

    pqs_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign in_stall  = (state_reg != S_IDLE) || o_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = o_valid_reg;
    assign out_type = o_type_reg;
    assign out_priority = o_pri_reg;
    assign out_blocking = o_blk_reg;
    assign skipped_ok = o_skip_reg;
    assign removed_ok = o_rem_reg;
    assign entry_count = held_reg;
    assign status = o_st_reg;

    logic [CW-1:0] cur_idx;
    logic signed [31:0] ins_p;
    logic [CW:0] skip_plus1;
    assign cur_idx = held_reg - CW'(1) - CW'(skip_reg);
    assign skip_plus1 = {1'b0, CW'(skip_reg)} + (CW+1)'(1);

    always_comb
    begin
        state_next = state_reg;
        held_next = held_reg;
        skip_next = skip_reg;
        top_next = top_reg;
        bot_next = bot_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        act_next = act_reg;
        new_next = new_reg;
        peek_next = peek_reg;
        o_type_next = o_type_reg;
        o_pri_next = o_pri_reg;
        o_blk_next = o_blk_reg;
        o_skip_next = o_skip_reg;
        o_rem_next = o_rem_reg;
        o_st_next = o_st_reg;
        o_valid_next = o_valid_reg && out_stall;
        we = 1'b0;
        waddr = AW'(idx_reg);
        wdata = new_reg;
        raddr = AW'(idx_reg);
        ins_p = item_priority;
        unique case (action)
            ACT_INSERT_TOP: ins_p = sat_add(top_reg, spacing_reg, 1'b0);
            ACT_INSERT_BOT: ins_p = sat_add(bot_reg, spacing_reg, 1'b1);
            default: ins_p = item_priority;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    act_next = action;
                    o_type_next = '0;
                    o_pri_next = '0;
                    o_blk_next = 1'b0;
                    o_skip_next = 1'b0;
                    o_rem_next = 1'b0;
                    o_st_next = ST_OK;
                    peek_next = 1'b0;
                    state_next = S_DONE;
                    unique case (action)
                        ACT_INSERT, ACT_INSERT_TOP, ACT_INSERT_BOT:
                        begin
                            new_next = '{item_type, ins_p, item_blocking};
                            if (held_reg >= DEPTH_C)
                                o_st_next = ST_FULL;
                            else
                            begin
                                logic signed [31:0] t, b;
                                t = (held_reg == '0) ? ins_p : top_reg;
                                b = (held_reg == '0) ? ins_p : bot_reg;
                                top_next = (ins_p > t) ? ins_p : t;
                                bot_next = (ins_p < b) ? ins_p : b;
                                if (ins_p <= b)
                                begin
                                    pos_next = '0;
                                    idx_next = held_reg;
                                    state_next = S_SHUPR;
                                end
                                else if (ins_p < t)
                                begin
                                    idx_next = '0;
                                    state_next = S_FIND;
                                end
                                else
                                begin
                                    pos_next = held_reg;
                                    idx_next = held_reg;
                                    state_next = S_SHUPR;
                                end
                            end
                        end
                        ACT_PEEK_TOP:
                        begin
                            skip_next = '0;
                            if (held_reg == '0)
                                o_st_next = ST_EMPTY;
                            else
                            begin
                                idx_next = held_reg - CW'(1);
                                peek_next = 1'b1;
                                state_next = S_TOPR;
                            end
                        end
                        ACT_PEEK_CUR, ACT_SKIP, ACT_POP_CUR:
                        begin
                            if (held_reg == '0)
                                o_st_next = ST_EMPTY;
                            else if ({1'b0, held_reg} < skip_plus1)
                                o_st_next = ST_RANGE;
                            else if (action == ACT_SKIP && {1'b0, held_reg} == skip_plus1)
                                o_st_next = ST_RANGE;
                            else if (action == ACT_POP_CUR)
                            begin
                                pos_next = cur_idx;
                                state_next = S_SHDNR;
                            end
                            else
                            begin
                                idx_next = cur_idx;
                                peek_next = (action == ACT_PEEK_CUR);
                                state_next = S_TOPR;
                            end
                        end
                        ACT_POP_TOP:
                        begin
                            if (held_reg == '0)
                                o_st_next = ST_EMPTY;
                            else
                            begin
                                held_next = held_reg - CW'(1);
                                if (held_reg == CW'(1))
                                begin
                                    top_next = '0;
                                    bot_next = '0;
                                end
                                else
                                begin
                                    idx_next = held_reg - CW'(2);
                                    state_next = S_TOPR;
                                end
                            end
                        end
                        ACT_REMOVE:
                        begin
                            new_next.item_type = item_type;
                            if (held_reg == '0)
                                o_st_next = ST_EMPTY;
                            else
                            begin
                                idx_next = '0;
                                state_next = S_FIND;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            held_next = '0;
                            top_next = '0;
                            bot_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FIND:
            begin
                // Registered read of entry idx_reg.
                state_next = S_FINDW;
            end
            S_FINDW:
            begin
                if (act_reg == ACT_REMOVE)
                begin
                    if (rdata.item_type == new_reg.item_type)
                    begin
                        o_rem_next = 1'b1;
                        pos_next = idx_reg;
                        state_next = S_SHDNR;
                    end
                    else if (idx_reg + CW'(1) >= held_reg)
                        state_next = S_DONE;
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        raddr = AW'(idx_reg + CW'(1));
                        state_next = S_FIND;
                    end
                end
                else
                begin
                    if (idx_reg < held_reg && rdata.priority_value <= new_reg.priority_value)
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_FIND;
                    end
                    else
                    begin
                        pos_next = idx_reg;
                        idx_next = held_reg;
                        state_next = S_SHUPR;
                    end
                end
            end
            S_SHUPR:
            begin
                if (idx_reg == pos_reg)
                begin
                    we = 1'b1;
                    waddr = AW'(pos_reg);
                    wdata = new_reg;
                    held_next = held_reg + CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = AW'(idx_reg - CW'(1));
                    state_next = S_SHUPW;
                end
            end
            S_SHUPW:
            begin
                we = 1'b1;
                waddr = AW'(idx_reg);
                wdata = rdata;
                idx_next = idx_reg - CW'(1);
                state_next = S_SHUPR;
            end
            S_SHDNR:
            begin
                if (pos_reg + CW'(1) >= held_reg)
                begin
                    held_next = held_reg - CW'(1);
                    if (act_reg == ACT_POP_CUR)
                    begin
                        if (held_reg == CW'(1))
                        begin
                            top_next = '0;
                            bot_next = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next = held_reg - CW'(2);
                            state_next = S_TOPR;
                        end
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    raddr = AW'(pos_reg + CW'(1));
                    state_next = S_SHDNW;
                end
            end
            S_SHDNW:
            begin
                we = 1'b1;
                waddr = AW'(pos_reg);
                wdata = rdata;
                pos_next = pos_reg + CW'(1);
                state_next = S_SHDNR;
            end
            S_TOPR:
            begin
                // idx_reg drives raddr; data arrives in S_DONE handling below.
                state_next = S_DONE;
            end
            S_DONE:
            begin
                unique case (act_reg)
                    ACT_PEEK_TOP, ACT_PEEK_CUR:
                    begin
                        if (peek_reg)
                        begin
                            o_type_next = rdata.item_type;
                            o_pri_next = rdata.priority_value;
                            o_blk_next = rdata.blocking;
                        end
                    end
                    ACT_SKIP:
                    begin
                        if (o_st_next == ST_OK && !rdata.blocking)
                        begin
                            skip_next = skip_reg + AW'(1);
                            o_skip_next = 1'b1;
                        end
                    end
                    ACT_POP_TOP, ACT_POP_CUR:
                    begin
                        if (o_st_reg == ST_OK && held_reg != '0)
                            top_next = rdata.priority_value;
                    end
                    default: ;
                endcase
                o_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;
            skip_reg <= '0;
            top_reg <= '0;
            bot_reg <= '0;
            spacing_reg <= SPACING_RESET;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            o_valid_reg <= o_valid_next;
            held_reg <= held_next;
            skip_reg <= skip_next;
            top_reg <= top_next;
            bot_reg <= bot_next;
            if (cfg_valid && cfg_ready)
                spacing_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        act_reg <= act_next;
        new_reg <= new_next;
        peek_reg <= peek_next;
        o_type_reg <= o_type_next;
        o_pri_reg <= o_pri_next;
        o_blk_reg <= o_blk_next;
        o_skip_reg <= o_skip_next;
        o_rem_reg <= o_rem_next;
        o_st_reg <= o_st_next;
    end

    `PQS_ASSERT_IMPLY(a_count_range, clk, rst_n, 1'b1, held_reg <= DEPTH_C)
    `PQS_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `PQS_ASSERT_NEXT(a_empty_marks, clk, rst_n,
        state_reg == S_IDLE && in_valid && !in_stall && action == ACT_CLEAR,
        held_reg == '0 && top_reg == '0)

endmodule

// ===== tb/tb_priority_queue_with_skip.sv =====
module tb_priority_queue_with_skip;
    import pqs_pkg::*;

    localparam int QDEPTH = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [15:0]        typ;
        logic signed [31:0] pri;
        logic               blk;
        logic               skipped;
        logic               removed;
        logic [6:0]         count;
        status_t            st;
    } queue_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         action;
    logic [15:0]        item_type;
    logic signed [31:0] item_priority;
    logic               item_blocking;
    logic               out_valid;
    logic               out_stall;
    logic [15:0]        out_type;
    logic signed [31:0] out_priority;
    logic               out_blocking;
    logic               skipped_ok;
    logic               removed_ok;
    logic [6:0]         entry_count;
    logic [1:0]         status;

    entry_t             model_entries [QDEPTH];
    int                 model_held;
    int                 model_skip;
    logic signed [31:0] model_top;
    logic signed [31:0] model_bottom;
    logic [15:0]        model_spacing;

    queue_result_t      pending_results [$];
    int                 error_count;
    int                 idle_pct;
    int                 stall_pct;
    int                 hold_cycles;

    priority_queue_with_skip u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .item_type(item_type),
        .item_priority(item_priority),
        .item_blocking(item_blocking),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_type(out_type),
        .out_priority(out_priority),
        .out_blocking(out_blocking),
        .skipped_ok(skipped_ok),
        .removed_ok(removed_ok),
        .entry_count(entry_count),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [31:0] offset_mark(logic signed [31:0] mark, bit down);
        longint v;
        v = down ? longint'(mark) - longint'(model_spacing) : longint'(mark) + longint'(model_spacing);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic status_t place_entry(logic [15:0] t, logic signed [31:0] p, logic b);
        int pos;
        if (model_held >= QDEPTH)
            return ST_FULL;
        if (model_held == 0)
        begin
            model_top = p;
            model_bottom = p;
        end
        if (p <= model_bottom)
            pos = 0;
        else if (p < model_top)
        begin
            pos = 0;
            while (pos < model_held && model_entries[pos].priority_value <= p)
                pos++;
        end
        else
            pos = model_held;
        for (int i = model_held; i > pos; i--)
            model_entries[i] = model_entries[i - 1];
        model_entries[pos] = '{item_type: t, priority_value: p, blocking: b};
        model_held++;
        if (p > model_top)
            model_top = p;
        if (p < model_bottom)
            model_bottom = p;
        return ST_OK;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < model_held; i++)
            model_entries[i] = model_entries[i + 1];
        model_held--;
    endfunction

    function automatic void retrack_top();
        if (model_held == 0)
        begin
            model_top = 0;
            model_bottom = 0;
        end
        else
            model_top = model_entries[model_held - 1].priority_value;
    endfunction

    function automatic queue_result_t predict_action(logic [3:0] a, logic [15:0] t,
                                                     logic signed [31:0] p, logic b);
        queue_result_t r;
        int shown;
        r = '{typ: '0, pri: '0, blk: 1'b0, skipped: 1'b0, removed: 1'b0, count: '0, st: ST_OK};
        shown = -1;
        case (a)
            ACT_INSERT: r.st = place_entry(t, p, b);
            ACT_INSERT_TOP: r.st = place_entry(t, offset_mark(model_top, 1'b0), b);
            ACT_INSERT_BOT: r.st = place_entry(t, offset_mark(model_bottom, 1'b1), b);
            ACT_PEEK_TOP:
            begin
                model_skip = 0;
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else
                    shown = model_held - 1;
            end
            ACT_PEEK_CUR:
            begin
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else if (model_skip >= model_held)
                    r.st = ST_RANGE;
                else
                    shown = model_held - 1 - model_skip;
            end
            ACT_SKIP:
            begin
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else if (model_held <= model_skip + 1)
                    r.st = ST_RANGE;
                else if (!model_entries[model_held - 1 - model_skip].blocking)
                begin
                    model_skip++;
                    r.skipped = 1'b1;
                end
            end
            ACT_POP_TOP:
            begin
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    model_held--;
                    retrack_top();
                end
            end
            ACT_POP_CUR:
            begin
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else if (model_skip >= model_held)
                    r.st = ST_RANGE;
                else
                begin
                    drop_entry(model_held - 1 - model_skip);
                    retrack_top();
                end
            end
            ACT_REMOVE:
            begin
                if (model_held == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < model_held; i++)
                    begin
                        if (model_entries[i].item_type == t)
                        begin
                            drop_entry(i);
                            r.removed = 1'b1;
                            break;
                        end
                    end
                end
            end
            ACT_CLEAR:
            begin
                model_held = 0;
                model_top = 0;
                model_bottom = 0;
            end
            default: ;
        endcase
        if (shown >= 0)
        begin
            r.typ = model_entries[shown].item_type;
            r.pri = model_entries[shown].priority_value;
            r.blk = model_entries[shown].blocking;
        end
        r.count = 7'(model_held);
        return r;
    endfunction

    task automatic send_action(logic [3:0] a, logic [15:0] t, logic signed [31:0] p, logic b);
        queue_result_t exp_r;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        action <= a;
        item_type <= t;
        item_priority <= p;
        item_blocking <= b;
        do
            @(posedge clk);
        while (in_stall);
        exp_r = predict_action(a, t, p, b);
        pending_results = {pending_results, exp_r};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_spacing(logic [15:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_spacing = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_priority();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 15) - 8;
        if (r < 85)
            return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'sh8000_0000 + $urandom_range(0, 3);
    endfunction

    function automatic logic [15:0] pick_type();
        return ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    endfunction

    task automatic send_random(bit filling);
        int r;
        logic [3:0] a;
        r = $urandom_range(0, 99);
        if (r < 3)
            a = 4'($urandom_range(10, 15));
        else if (r < (filling ? 58 : 23))
            a = 4'($urandom_range(0, 2));
        else if (r < 97)
            a = 4'($urandom_range(3, 8));
        else
            a = ACT_CLEAR;
        send_action(a, pick_type(), pick_priority(), 1'($urandom));
    endtask

    task automatic test_directed();
        send_action(ACT_PEEK_TOP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_PEEK_CUR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_SKIP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_POP_TOP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_POP_CUR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_REMOVE, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_INSERT, 16'hFFFF, 32'sh7FFF_FFF0, 1'b1);
        send_action(ACT_INSERT, 16'h0001, 32'sh8000_0000, 1'b0);
        send_action(ACT_INSERT, 16'h0002, 32'sd0, 1'b0);
        send_action(ACT_INSERT, 16'h0003, 32'sd0, 1'b1);
        send_action(ACT_INSERT_TOP, 16'h0004, 32'sd0, 1'b0);
        send_action(ACT_INSERT_BOT, 16'h0005, 32'sd0, 1'b0);
        send_action(ACT_PEEK_TOP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_SKIP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_SKIP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_PEEK_CUR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_POP_CUR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_POP_TOP, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_REMOVE, 16'h0009, 32'sd0, 1'b0);
        send_action(ACT_REMOVE, 16'h0003, 32'sd0, 1'b0);
        send_action(4'd15, 16'hFFFF, 32'sh7FFF_FFFF, 1'b1);
        send_action(ACT_CLEAR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_INSERT, 16'h0006, -32'sd1, 1'b0);
        send_action(ACT_PEEK_CUR, 16'h0, 32'sd0, 1'b0);
        send_action(ACT_SKIP, 16'h0, 32'sd0, 1'b0);
    endtask

    task automatic test_spacing_extremes();
        write_spacing(16'hFFFF);
        send_action(ACT_INSERT, 16'h0007, 32'sh7FFF_FF00, 1'b0);
        send_action(ACT_INSERT_TOP, 16'h0008, 32'sd0, 1'b0);
        send_action(ACT_INSERT, 16'h0009, 32'sh8000_0100, 1'b1);
        send_action(ACT_INSERT_BOT, 16'h000A, 32'sd0, 1'b0);
        write_spacing(16'h0000);
        send_action(ACT_INSERT_TOP, 16'h000B, 32'sd0, 1'b0);
        send_action(ACT_INSERT_BOT, 16'h000C, 32'sd0, 1'b1);
        send_action(ACT_PEEK_TOP, 16'h0, 32'sd0, 1'b0);
    endtask

    task automatic test_backpressure();
        write_spacing(16'd3);
        hold_cycles = 600;
        for (int i = 0; i < 80; i++)
            send_action(ACT_INSERT, pick_type(), pick_priority(), 1'($urandom));
        wait_drained();
        for (int i = 0; i < 70; i++)
            send_random(1'b0);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            write_spacing(16'($urandom));
            for (int i = 0; i < 130; i++)
                send_random(((i / 50) % 2) == 0);
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = '0;
        item_type = '0;
        item_priority = '0;
        item_blocking = 1'b0;
        out_stall = 1'b0;
        error_count = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        model_held = 0;
        model_skip = 0;
        model_top = 0;
        model_bottom = 0;
        model_spacing = SPACING_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_spacing_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        queue_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual status %0d",
                         $time, status);
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("out_type", e.typ, out_type);
                check_field("out_priority", e.pri, out_priority);
                check_field("out_blocking", e.blk, out_blocking);
                check_field("skipped_ok", e.skipped, skipped_ok);
                check_field("removed_ok", e.removed, removed_ok);
                check_field("entry_count", e.count, entry_count);
                check_field("status", e.st, status);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end
endmodule
